[rtl/first_fit_heap_allocator_top_macros.svh]
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ffha assertion failed");
`define FFHA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_IMPL(label, clk, rst_n, a, b)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/ffha_pkg.sv]
// Shared constants, operation codes and interface types of the heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int DEF_HEAP_BYTES   = 512;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int REQ_W            = 16;
    localparam int OFF_W            = 9;
    localparam int OP_W             = 5;

    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_RD_CUR    = 5'd2;
    localparam logic [OP_W-1:0] OP_ADV       = 5'd3;
    localparam logic [OP_W-1:0] OP_A_TAKE    = 5'd4;
    localparam logic [OP_W-1:0] OP_A_SPLIT   = 5'd5;
    localparam logic [OP_W-1:0] OP_A_SHRINK  = 5'd6;
    localparam logic [OP_W-1:0] OP_A_UNLINK  = 5'd7;
    localparam logic [OP_W-1:0] OP_F_END     = 5'd8;
    localparam logic [OP_W-1:0] OP_RD_BLK    = 5'd9;
    localparam logic [OP_W-1:0] OP_F_GETB    = 5'd10;
    localparam logic [OP_W-1:0] OP_F_GETC    = 5'd11;
    localparam logic [OP_W-1:0] OP_F_MPREV   = 5'd12;
    localparam logic [OP_W-1:0] OP_F_MNEXT   = 5'd13;
    localparam logic [OP_W-1:0] OP_F_LINK    = 5'd14;
    localparam logic [OP_W-1:0] OP_DONE_OK   = 5'd15;
    localparam logic [OP_W-1:0] OP_DONE_FAIL = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic walk_ok;
        logic fit;
        logic free_null;
        logic free_bad;
        logic scan_more;
        logic steps_max;
    } sts_t;

endpackage

[rtl/ffha_controller.sv]
// Sequencer that walks the free list and orders header updates.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_top_macros.svh"
module ffha_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          action,
    output logic          busy,
    output ffha_pkg::cmd_t cmd,
    input  ffha_pkg::sts_t sts
);
    import ffha_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_TEST = 4'd1;
    localparam logic [3:0] S_A_EVAL = 4'd2;
    localparam logic [3:0] S_A_W1   = 4'd3;
    localparam logic [3:0] S_A_W2   = 4'd4;
    localparam logic [3:0] S_A_W3   = 4'd5;
    localparam logic [3:0] S_F_CHK  = 4'd6;
    localparam logic [3:0] S_F_TEST = 4'd7;
    localparam logic [3:0] S_F_ADV  = 4'd8;
    localparam logic [3:0] S_F_RDB  = 4'd9;
    localparam logic [3:0] S_F_RDC  = 4'd10;
    localparam logic [3:0] S_F_MP   = 4'd11;
    localparam logic [3:0] S_F_W1   = 4'd12;
    localparam logic [3:0] S_F_W2   = 4'd13;
    localparam logic [3:0] S_F_W3   = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = action ? S_F_CHK : S_A_TEST;
                end
            end
            S_A_TEST:
            begin
                if (sts.walk_ok)
                begin
                    cmd.op     = OP_RD_CUR;
                    state_next = S_A_EVAL;
                end
                else
                begin
                    cmd.op     = OP_DONE_FAIL;
                    state_next = S_IDLE;
                end
            end
            S_A_EVAL:
            begin
                if (sts.fit)
                begin
                    cmd.op     = OP_A_TAKE;
                    state_next = S_A_W1;
                end
                else
                begin
                    cmd.op     = OP_ADV;
                    state_next = S_A_TEST;
                end
            end
            S_A_W1:
            begin
                cmd.op     = OP_A_SPLIT;
                state_next = S_A_W2;
            end
            S_A_W2:
            begin
                cmd.op     = OP_A_SHRINK;
                state_next = S_A_W3;
            end
            S_A_W3:
            begin
                cmd.op     = OP_A_UNLINK;
                state_next = S_IDLE;
            end
            S_F_CHK:
            begin
                if (sts.free_null)
                begin
                    cmd.op     = OP_DONE_OK;
                    state_next = S_IDLE;
                end
                else if (sts.free_bad)
                begin
                    cmd.op     = OP_DONE_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_F_TEST;
                end
            end
            S_F_TEST:
            begin
                if (!sts.scan_more)
                begin
                    state_next = S_F_RDB;
                end
                else if (sts.steps_max)
                begin
                    cmd.op     = OP_F_END;
                    state_next = S_F_RDB;
                end
                else
                begin
                    cmd.op     = OP_RD_CUR;
                    state_next = S_F_ADV;
                end
            end
            S_F_ADV:
            begin
                cmd.op     = OP_ADV;
                state_next = S_F_TEST;
            end
            S_F_RDB:
            begin
                cmd.op     = OP_RD_BLK;
                state_next = S_F_RDC;
            end
            S_F_RDC:
            begin
                cmd.op     = OP_F_GETB;
                state_next = S_F_MP;
            end
            S_F_MP:
            begin
                cmd.op     = OP_F_GETC;
                state_next = S_F_W1;
            end
            S_F_W1:
            begin
                cmd.op     = OP_F_MPREV;
                state_next = S_F_W2;
            end
            S_F_W2:
            begin
                cmd.op     = OP_F_MNEXT;
                state_next = S_F_W3;
            end
            S_F_W3:
            begin
                cmd.op     = OP_F_LINK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FFHA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `FFHA_ASSERT_IMPL(a_eval_after_read, clk, rst_n, state_reg == S_A_EVAL,
        $past(cmd.op) == OP_RD_CUR)
    `FFHA_ASSERT_IMPL(a_idle_ops, clk, rst_n, !busy,
        cmd.op == OP_NONE || cmd.op == OP_LOAD)

endmodule

[rtl/ffha_datapath.sv]
// Header stores, list pointers and result registers of the heap allocator.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_top_macros.svh"
module ffha_datapath #(
    parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffha_pkg::cmd_t             cmd,
    output ffha_pkg::sts_t             sts,
    input  logic [ffha_pkg::REQ_W-1:0] request_size,
    input  logic [ffha_pkg::OFF_W-1:0] release_offset,
    output logic                       done,
    output logic [ffha_pkg::OFF_W-1:0] granted_offset,
    output logic                       success
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int LW = $clog2(HEAP_BYTES + 1);
    localparam int SW = $clog2(2 * HEAP_BYTES);
    localparam int XW = ((SW > REQ_W) ? SW : REQ_W) + 3;
    localparam logic [XW-1:0] END_X = XW'(HEAP_BYTES);
    localparam logic [XW-1:0] HDR_X = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] CAP_X = XW'(2 * HEAP_BYTES - 1);
    localparam logic [LW-1:0] END_L = LW'(HEAP_BYTES);
    localparam logic [SW-1:0] SZ0   = SW'(HEAP_BYTES - HEADER_BYTES);

    logic [SW-1:0] size_mem [HEAP_BYTES];
    logic [LW-1:0] link_mem [HEAP_BYTES];

    logic [REQ_W-1:0] want_reg;
    logic [OFF_W-1:0] off_reg;
    logic [LW-1:0]    cur_reg, prev_reg, steps_reg, blk_reg, head_reg;
    logic [LW-1:0]    lk_reg, part_reg, clnk_reg;
    logic [SW-1:0]    sz_reg, psz_reg, bsz_reg, csz_reg;
    logic             split_reg;
    logic [SW-1:0]    szq_reg;
    logic [LW-1:0]    lkq_reg;
    logic             szhit_reg, lkhit_reg, sz0_wr_reg, lk0_wr_reg;
    logic             done_reg, success_reg;
    logic [OFF_W-1:0] granted_reg;

    logic [AW-1:0] raddr;
    logic          sw_en, lw_en;
    logic [AW-1:0] sw_addr, lw_addr;
    logic [SW-1:0] sw_data;
    logic [LW-1:0] lw_data;
    logic [SW-1:0] rd_sz;
    logic [LW-1:0] rd_lk_raw, rd_lk;
    logic [XW-1:0] want_x, off_x, cur_x, prev_x, blk_x, rem_x, part_x;
    logic [XW-1:0] mprev_sum, mnext_sum, mnext_end;
    logic          mprev_hit, mnext_hit;

    function automatic logic [SW-1:0] cap(input logic [XW-1:0] v);
        cap = (v > CAP_X) ? CAP_X[SW-1:0] : v[SW-1:0];
    endfunction

    assign want_x = XW'(want_reg);
    assign off_x  = XW'(off_reg);
    assign cur_x  = XW'(cur_reg);
    assign prev_x = XW'(prev_reg);
    assign blk_x  = XW'(blk_reg);

    assign rd_sz     = szhit_reg ? SZ0 : szq_reg;
    assign rd_lk_raw = lkhit_reg ? END_L : lkq_reg;
    assign rd_lk     = (rd_lk_raw >= END_L) ? END_L : rd_lk_raw;

    assign rem_x  = XW'(rd_sz) - want_x;
    assign part_x = cur_x + HDR_X + want_x;

    assign mprev_sum = XW'(psz_reg) + HDR_X + XW'(bsz_reg);
    assign mprev_hit = (prev_reg < END_L) && (prev_x + HDR_X + XW'(psz_reg) == blk_x);
    assign mnext_sum = XW'(bsz_reg) + HDR_X + XW'(csz_reg);
    assign mnext_end = blk_x + HDR_X + XW'(bsz_reg);
    assign mnext_hit = (cur_reg < END_L) && (mnext_end == cur_x);

    assign sts.walk_ok   = (cur_reg < END_L) && (steps_reg < END_L);
    assign sts.fit       = (XW'(rd_sz) >= want_x);
    assign sts.free_null = (off_reg == '0);
    assign sts.free_bad  = (off_x < HDR_X) || ((off_x - HDR_X) >= END_X);
    assign sts.scan_more = (cur_reg < END_L) && (cur_reg < blk_reg);
    assign sts.steps_max = (steps_reg >= END_L);

    always_comb
    begin
        if (cmd.op == OP_RD_BLK)
        begin
            raddr = blk_reg[AW-1:0];
        end
        else if (cur_reg < END_L)
        begin
            raddr = cur_reg[AW-1:0];
        end
        else
        begin
            raddr = '0;
        end
    end

    always_comb
    begin
        sw_en   = 1'b0;
        lw_en   = 1'b0;
        sw_addr = cur_reg[AW-1:0];
        lw_addr = cur_reg[AW-1:0];
        sw_data = '0;
        lw_data = '0;
        case (cmd.op)
            OP_A_SPLIT:
            begin
                sw_en   = split_reg;
                lw_en   = split_reg;
                sw_addr = part_reg[AW-1:0];
                lw_addr = part_reg[AW-1:0];
                sw_data = cap(XW'(sz_reg) - want_x - HDR_X);
                lw_data = lk_reg;
            end
            OP_A_SHRINK:
            begin
                sw_en   = split_reg;
                lw_en   = split_reg;
                sw_data = cap(want_x);
                lw_data = part_reg;
            end
            OP_A_UNLINK:
            begin
                lw_en   = (prev_reg < END_L);
                lw_addr = prev_reg[AW-1:0];
                lw_data = lk_reg;
            end
            OP_F_MPREV:
            begin
                sw_en   = mprev_hit;
                sw_addr = prev_reg[AW-1:0];
                sw_data = cap(mprev_sum);
            end
            OP_F_MNEXT:
            begin
                sw_en   = mnext_hit;
                lw_en   = 1'b1;
                sw_addr = blk_reg[AW-1:0];
                lw_addr = blk_reg[AW-1:0];
                sw_data = cap(mnext_sum);
                lw_data = mnext_hit ? clnk_reg : cur_reg;
            end
            OP_F_LINK:
            begin
                lw_en   = (prev_reg < END_L) && (prev_reg != blk_reg);
                lw_addr = prev_reg[AW-1:0];
                lw_data = blk_reg;
            end
            default:
            begin
                sw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            size_mem[sw_addr] <= sw_data;
        end
        if (lw_en)
        begin
            link_mem[lw_addr] <= lw_data;
        end
        szq_reg <= size_mem[raddr];
        lkq_reg <= link_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            sz0_wr_reg  <= 1'b0;
            lk0_wr_reg  <= 1'b0;
            szhit_reg   <= 1'b0;
            lkhit_reg   <= 1'b0;
            done_reg    <= 1'b0;
            success_reg <= 1'b0;
            granted_reg <= '0;
        end
        else
        begin
            szhit_reg <= (raddr == '0) && !(sz0_wr_reg || (sw_en && sw_addr == '0));
            lkhit_reg <= (raddr == '0) && !(lk0_wr_reg || (lw_en && lw_addr == '0));
            if (sw_en && sw_addr == '0)
            begin
                sz0_wr_reg <= 1'b1;
            end
            if (lw_en && lw_addr == '0)
            begin
                lk0_wr_reg <= 1'b1;
            end
            done_reg <= 1'b0;
            case (cmd.op)
                OP_A_UNLINK:
                begin
                    if (prev_reg >= END_L)
                    begin
                        head_reg <= lk_reg;
                    end
                    done_reg    <= 1'b1;
                    success_reg <= 1'b1;
                    granted_reg <= cur_x[OFF_W-1:0] + HDR_X[OFF_W-1:0];
                end
                OP_F_LINK:
                begin
                    if (prev_reg >= END_L)
                    begin
                        head_reg <= blk_reg;
                    end
                    done_reg    <= 1'b1;
                    success_reg <= 1'b1;
                    granted_reg <= '0;
                end
                OP_DONE_OK:
                begin
                    done_reg    <= 1'b1;
                    success_reg <= 1'b1;
                    granted_reg <= '0;
                end
                OP_DONE_FAIL:
                begin
                    done_reg    <= 1'b1;
                    success_reg <= 1'b0;
                    granted_reg <= '0;
                end
                default:
                begin
                    done_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                want_reg  <= request_size;
                off_reg   <= release_offset;
                cur_reg   <= (head_reg >= END_L) ? END_L : head_reg;
                prev_reg  <= END_L;
                steps_reg <= '0;
                blk_reg   <= LW'(XW'(release_offset) - HDR_X);
            end
            OP_ADV:
            begin
                prev_reg  <= cur_reg;
                psz_reg   <= rd_sz;
                cur_reg   <= rd_lk;
                steps_reg <= steps_reg + LW'(1);
            end
            OP_A_TAKE:
            begin
                sz_reg    <= rd_sz;
                lk_reg    <= rd_lk;
                part_reg  <= part_x[LW-1:0];
                split_reg <= (rem_x > HDR_X) && (part_x < END_X);
            end
            OP_A_SHRINK:
            begin
                if (split_reg)
                begin
                    lk_reg <= part_reg;
                end
            end
            OP_F_END:
            begin
                cur_reg <= END_L;
            end
            OP_F_GETB:
            begin
                bsz_reg <= rd_sz;
            end
            OP_F_GETC:
            begin
                csz_reg  <= rd_sz;
                clnk_reg <= rd_lk;
            end
            OP_F_MPREV:
            begin
                if (mprev_hit)
                begin
                    blk_reg <= prev_reg;
                    bsz_reg <= cap(mprev_sum);
                end
            end
            default:
            begin
                sz_reg <= sz_reg;
            end
        endcase
    end

    assign done           = done_reg;
    assign success        = success_reg;
    assign granted_offset = granted_reg;

    `FFHA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `FFHA_ASSERT_IMPL(a_head_bound, clk, rst_n, 1'b1, head_reg <= END_L)
    `FFHA_ASSERT_IMPL(a_grant_ok, clk, rst_n, done_reg && granted_reg != '0, success_reg)

endmodule

[rtl/first_fit_heap_allocator_top.sv]
// Allocate time grows with the free blocks visited, free time with the free
// blocks below the offset; null or bad frees finish without a list walk. The
// walk goes through the header store read port. One transaction at a time: busy
// stays high until the result strobe, which lasts one cycle and cannot stall.
// Reset is asynchronous and leaves one free block spanning the heap at once.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       action,
    input  logic [ffha_pkg::REQ_W-1:0] request_size,
    input  logic [ffha_pkg::OFF_W-1:0] release_offset,
    output logic                       done,
    output logic [ffha_pkg::OFF_W-1:0] granted_offset,
    output logic                       success
);
    import ffha_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffha_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd),
        .sts    (sts)
    );

    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .request_size   (request_size),
        .release_offset (release_offset),
        .done           (done),
        .granted_offset (granted_offset),
        .success        (success)
    );

endmodule

[sim/heap_alloc_checker.sv]
// Checker for the heap allocator: predicts each transaction's result and compares it.
`timescale 1ns / 1ps
module heap_alloc_checker #(
    parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       action,
    input  logic [ffha_pkg::REQ_W-1:0] request_size,
    input  logic [ffha_pkg::OFF_W-1:0] release_offset,
    input  logic                       done,
    input  logic [ffha_pkg::OFF_W-1:0] granted_offset,
    input  logic                       success,
    output int                         mismatch_count,
    output int                         pending_count
);

    localparam int unsigned LIST_END = HEAP_BYTES;
    localparam int unsigned SIZE_CAP = 2 * HEAP_BYTES - 1;
    localparam logic ACT_ALLOC = 1'b0;

    typedef struct packed {
        logic [ffha_pkg::OFF_W-1:0] offset;
        logic                       ok;
    } grant_t;

    grant_t      expected_grants[$];
    int unsigned hdr_size[HEAP_BYTES];
    int unsigned hdr_link[HEAP_BYTES];
    int unsigned list_head;

    function automatic int unsigned link_of(int unsigned at);
        if (at >= LIST_END)
            return LIST_END;
        return hdr_link[at] >= LIST_END ? LIST_END : hdr_link[at];
    endfunction

    function automatic int unsigned size_of(int unsigned at);
        return at < LIST_END ? hdr_size[at] : 0;
    endfunction

    function automatic void put_link(int unsigned at, int unsigned to);
        if (at < LIST_END)
            hdr_link[at] = to >= LIST_END ? LIST_END : to;
    endfunction

    function automatic void put_size(int unsigned at, int unsigned v);
        if (at < LIST_END)
            hdr_size[at] = v > SIZE_CAP ? SIZE_CAP : v;
    endfunction

    function automatic int unsigned first_fit(int unsigned want);
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        int unsigned sz;
        int unsigned part;
        prev = LIST_END;
        cur = list_head >= LIST_END ? LIST_END : list_head;
        steps = 0;
        while (cur < LIST_END && steps < HEAP_BYTES) begin
            sz = size_of(cur);
            if (sz >= want) begin
                if (sz - want > HEADER_BYTES) begin
                    part = cur + HEADER_BYTES + want;
                    if (part < LIST_END) begin
                        put_size(part, sz - want - HEADER_BYTES);
                        put_link(part, link_of(cur));
                        put_size(cur, want);
                        put_link(cur, part);
                    end
                end
                if (prev >= LIST_END)
                    list_head = link_of(cur);
                else
                    put_link(prev, link_of(cur));
                return cur + HEADER_BYTES;
            end
            prev = cur;
            cur = link_of(cur);
            steps++;
        end
        return 0;
    endfunction

    function automatic logic release_block(int unsigned off);
        int unsigned blk;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        if (off == 0)
            return 1'b1;
        if (off < HEADER_BYTES)
            return 1'b0;
        blk = off - HEADER_BYTES;
        if (blk >= LIST_END)
            return 1'b0;
        prev = LIST_END;
        steps = 0;
        cur = list_head >= LIST_END ? LIST_END : list_head;
        while (cur < LIST_END && cur < blk) begin
            if (steps >= HEAP_BYTES) begin
                cur = LIST_END;
                break;
            end
            prev = cur;
            cur = link_of(cur);
            steps++;
        end
        if (prev < LIST_END && prev + HEADER_BYTES + size_of(prev) == blk) begin
            put_size(prev, size_of(prev) + HEADER_BYTES + size_of(blk));
            blk = prev;
        end
        if (cur < LIST_END && blk + HEADER_BYTES + size_of(blk) == cur) begin
            put_size(blk, size_of(blk) + HEADER_BYTES + size_of(cur));
            put_link(blk, link_of(cur));
            if (prev < LIST_END && prev != blk)
                put_link(prev, blk);
            if (prev >= LIST_END)
                list_head = blk;
        end else begin
            put_link(blk, cur);
            if (prev >= LIST_END)
                list_head = blk;
            else if (prev != blk)
                put_link(prev, blk);
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t seen;
        int unsigned got;
        if (!rst_n) begin
            for (int i = 0; i < HEAP_BYTES; i++) begin
                hdr_size[i] = 0;
                hdr_link[i] = 0;
            end
            hdr_size[0] = HEAP_BYTES - HEADER_BYTES;
            hdr_link[0] = LIST_END;
            list_head = 0;
            expected_grants.delete();
            mismatch_count <= 0;
        end else begin
            if (done) begin
                seen.offset = granted_offset;
                seen.ok = success;
                if (expected_grants.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("ERROR: unexpected result offset=%0d success=%0b",
                                 seen.offset, seen.ok);
                end else begin
                    want = expected_grants.pop_front();
                    if (want !== seen) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("ERROR: offset exp %0d got %0d, success exp %0b got %0b",
                                     want.offset, seen.offset, want.ok, seen.ok);
                    end
                end
            end
            if (start && !busy) begin
                if (action == ACT_ALLOC) begin
                    got = first_fit(request_size);
                    want.offset = got[ffha_pkg::OFF_W-1:0];
                    want.ok = got != 0;
                end else begin
                    want.offset = '0;
                    want.ok = release_block(release_offset);
                end
                expected_grants.push_back(want);
            end
        end
        pending_count <= expected_grants.size();
    end

endmodule

[sim/first_fit_heap_allocator_top_test.sv]
// Testbench top for the first-fit heap allocator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top_test;

    localparam int  ITEM_COUNT = 1050;
    localparam int  STALL_LIMIT = 20000;
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       action;
    logic [ffha_pkg::REQ_W-1:0] request_size;
    logic [ffha_pkg::OFF_W-1:0] release_offset;
    logic                       done;
    logic [ffha_pkg::OFF_W-1:0] granted_offset;
    logic                       success;
    int                         mismatch_count;
    int                         pending_count;

    logic [ffha_pkg::OFF_W-1:0] live_blocks[$];
    int                         idle_pct;
    int                         quiet_cycles;
    int                         grants_made;
    int                         frees_made;

    first_fit_heap_allocator_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .request_size(request_size),
        .release_offset(release_offset), .done(done),
        .granted_offset(granted_offset), .success(success)
    );

    heap_alloc_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .request_size(request_size),
        .release_offset(release_offset), .done(done),
        .granted_offset(granted_offset), .success(success),
        .mismatch_count(mismatch_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic run_transaction(input logic act, input logic [15:0] size,
                                   input logic [8:0] off);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(1, 5)) : 0;
        repeat (gap) @(posedge clk);
        start <= 1'b1;
        action <= act;
        request_size <= size;
        release_offset <= off;
        do @(posedge clk); while (!(start && !busy));
        start <= 1'b0;
        action <= 1'($urandom_range(1));
        request_size <= 16'($urandom);
        release_offset <= 9'($urandom);
        do @(posedge clk); while (!done);
        if (act == ACT_ALLOC && success && granted_offset != 0) begin
            live_blocks.push_back(granted_offset);
            grants_made++;
        end
        if (act == ACT_FREE)
            frees_made++;
    endtask

    task automatic release_live(input int idx);
        logic [8:0] off;
        off = live_blocks[idx];
        live_blocks.delete(idx);
        run_transaction(ACT_FREE, 16'($urandom), off);
    endtask

    initial
    begin
        int pick;
        logic [15:0] size;
        start = 1'b0;
        action = 1'b0;
        request_size = '0;
        release_offset = '0;
        quiet_cycles = 0;
        grants_made = 0;
        frees_made = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_transaction(ACT_ALLOC, 16'd0, 9'd0);
        run_transaction(ACT_ALLOC, 16'hFFFF, 9'h1FF);
        run_transaction(ACT_ALLOC, 16'd100, 9'd0);
        run_transaction(ACT_ALLOC, 16'd40, 9'd0);
        run_transaction(ACT_ALLOC, 16'd24, 9'd0);
        run_transaction(ACT_ALLOC, 16'd60, 9'd0);
        run_transaction(ACT_FREE, 16'd0, 9'd0);
        run_transaction(ACT_FREE, 16'd0, 9'd1);
        run_transaction(ACT_FREE, 16'hFFFF, 9'd15);
        release_live(2);
        release_live(1);
        release_live(2);
        run_transaction(ACT_ALLOC, 16'd500, 9'd0);
        run_transaction(ACT_ALLOC, 16'd200, 9'd0);
        run_transaction(ACT_ALLOC, 16'd16, 9'd0);
        run_transaction(ACT_ALLOC, 16'd17, 9'd0);
        while (live_blocks.size() > 0)
            release_live(0);
        run_transaction(ACT_ALLOC, 16'd496, 9'd0);
        run_transaction(ACT_ALLOC, 16'd1, 9'd0);
        release_live(0);

        for (int n = 0; n < ITEM_COUNT; n++) begin
            case ((n * 4) / ITEM_COUNT)
                1: idle_pct = 57;
                2: idle_pct = 13;
                default: idle_pct = 0;
            endcase
            pick = $urandom_range(99);
            if (live_blocks.size() > 0 && pick < 45) begin
                release_live($urandom_range(live_blocks.size() - 1));
            end else if (pick < 49) begin
                run_transaction(ACT_FREE, 16'($urandom),
                                pick < 47 ? 9'd0 : 9'($urandom_range(1, 15)));
            end else begin
                pick = $urandom_range(99);
                if (pick < 80)
                    size = 16'($urandom_range(0, 96));
                else if (pick < 95)
                    size = 16'($urandom_range(97, 496));
                else
                    size = 16'($urandom);
                run_transaction(ACT_ALLOC, size, 9'($urandom));
            end
        end

        // double free corrupts the list, so leave it for last
        if (live_blocks.size() == 0)
            run_transaction(ACT_ALLOC, 16'd8, 9'd0);
        if (live_blocks.size() > 0) begin
            pick = int'(live_blocks[0]);
            release_live(0);
            run_transaction(ACT_FREE, 16'd0, pick[8:0]);
            run_transaction(ACT_ALLOC, 16'd4, 9'd0);
            run_transaction(ACT_ALLOC, 16'd4, 9'd0);
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d grants and %0d frees, with idle phases of 0, 13 and 57 percent.",
                 grants_made, frees_made);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_controller.sv
rtl/ffha_datapath.sv
rtl/first_fit_heap_allocator_top.sv
sim/heap_alloc_checker.sv
sim/first_fit_heap_allocator_top_test.sv
